// ----- sv/particle_cell_remap_core_assert.svh -----
// assertion macros for the particle cell remap rtl
`ifndef PARTICLE_CELL_REMAP_CORE_ASSERT_SVH
`define PARTICLE_CELL_REMAP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// condition must hold in the same cycle as the trigger
`define PCR_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);
// condition must hold in the cycle after the trigger
`define PCR_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define PCR_ASSERT_SAME(label, trig, cond, msg)
`define PCR_ASSERT_NEXT(label, trig, cond, msg)
`endif

`endif

// ----- sv/pcr_pkg.sv -----
// types, widths and register codes of the particle cell remap block
package pcr_pkg;

	// build-time geometry
	localparam int NUM_AXES  = 3;
	localparam int DIMS      = 3;
	localparam int CELL_BITS = 10;
	localparam int FRAC_BITS = 16;

	// register and fixed-point widths
	localparam int SCALE_W    = 24;
	localparam int SHIFT_W    = 32;
	localparam int GHOST_W    = 4;
	localparam int QBITS      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// datapath widths
	localparam int DIFF_W  = CELL_BITS + 1;
	localparam int MUL_W   = DIFF_W + SCALE_W + 1;
	localparam int WHOLE_W = ((MUL_W > SHIFT_W) ? MUL_W : SHIFT_W) + 1;
	localparam int AHI_W   = WHOLE_W - QBITS;
	localparam int PROD_W  = FRAC_BITS + SCALE_W;
	localparam int BHI_W   = PROD_W - FRAC_BITS;
	localparam int MID_W   = ((BHI_W > QBITS) ? BHI_W : QBITS) + 1;
	localparam int MHI_W   = MID_W - QBITS;
	localparam int CV_W    = AHI_W + 2;
	localparam int FRT_W   = QBITS + FRAC_BITS;

	// stream payload widths
	localparam int IN_W    = NUM_AXES * (CELL_BITS + FRAC_BITS);
	localparam int TDATA_W = ((IN_W + 7) / 8) * 8;

	typedef logic [CELL_BITS-1:0]     cell_t;
	typedef logic [FRAC_BITS-1:0]     frac_t;
	typedef logic [SCALE_W-1:0]       scale_t;
	typedef logic signed [SHIFT_W-1:0] shift_t;
	typedef logic [GHOST_W-1:0]       ghost_t;

	localparam cell_t  CELL_MAX    = '1;
	localparam frac_t  FRAC_MAX    = '1;
	localparam scale_t SCALE_RESET = scale_t'(1 << QBITS);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X   = 3'd0,
		REG_SCALE_Y   = 3'd1,
		REG_SCALE_Z   = 3'd2,
		REG_SHIFT_X   = 3'd3,
		REG_SHIFT_Y   = 3'd4,
		REG_SHIFT_Z   = 3'd5,
		REG_SRC_GHOST = 3'd6,
		REG_DST_GHOST = 3'd7
	} cfg_reg_t;

	// per-stage load enables handed from the pipeline control to the lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pcr_load_t;

endpackage

// ----- sv/particle_cell_remap_core.sv -----
// Particle cell remap core: moves a particle position into destination patch cells.
// Input stream s_*: one transfer carries cell and fraction of all three axes.
// Output stream m_*: one transfer per input, new cells and fractions in m_tdata,
// the clamp flag in m_tuser.
// Configuration: cfg_we/cfg_index/cfg_data write the scale, shift and ghost
// registers, one per write; write only while no particle is in flight.
// m_tvalid is the stage 4 valid bit: an input transfer is registered through
// stages 1 to 4 before it is offered. Throughput: one particle per cycle while
// m_tready does not stall; each axis lane has a four-stage pipeline (multipliers,
// shift add, fraction merge, cell add and clamp) whose stages stall as a chain.
// Reset: clears all stage valid bits, scales go to 1.0, shifts and ghosts to 0.
// Receiver stall: the output register holds its transfer; earlier stages keep
// filling bubbles, so up to four particles sit in the pipe before s_tready drops.
// Axes at or above the build-time dimension count pass through unchanged.
module particle_cell_remap_core import pcr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cell_x, cell_y, cell_z, frac_x, frac_y, frac_z, zero pad
	input  logic [TDATA_W-1:0]    s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// new_cell_x, new_cell_y, new_cell_z, new_frac_x, new_frac_y, new_frac_z, zero pad
	output logic [TDATA_W-1:0]    m_tdata,
	// out_of_range
	output logic [0:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "particle_cell_remap_core_assert.svh"

	scale_t    scale_q [NUM_AXES];
	shift_t    shift_q [NUM_AXES];
	ghost_t    src_ghosts_q;
	ghost_t    dst_ghosts_q;

	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      v_s4;
	pcr_load_t load;

	cell_t     new_cell [NUM_AXES];
	frac_t     new_frac [NUM_AXES];
	logic [NUM_AXES-1:0] clamped;
	logic      clamp_shape_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				scale_q[a] <= SCALE_RESET;
				shift_q[a] <= '0;
			end
			src_ghosts_q <= '0;
			dst_ghosts_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE_X:   scale_q[0] <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y:   scale_q[1] <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Z:   scale_q[2] <= cfg_data[SCALE_W-1:0];
				REG_SHIFT_X:   shift_q[0] <= cfg_data[SHIFT_W-1:0];
				REG_SHIFT_Y:   shift_q[1] <= cfg_data[SHIFT_W-1:0];
				REG_SHIFT_Z:   shift_q[2] <= cfg_data[SHIFT_W-1:0];
				REG_SRC_GHOST: src_ghosts_q <= cfg_data[GHOST_W-1:0];
				REG_DST_GHOST: dst_ghosts_q <= cfg_data[GHOST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// per-stage load enables: a stage loads when empty or its successor loads
	always_comb begin
		load.s4 = !v_s4 || m_tready;
		load.s3 = !v_s3 || load.s4;
		load.s2 = !v_s2 || load.s3;
		load.s1 = !v_s1 || load.s2;
	end

	assign s_tready = load.s1;

	// valid bits travel with the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (load.s1) v_s1 <= s_tvalid;
			if (load.s2) v_s2 <= v_s1;
			if (load.s3) v_s3 <= v_s2;
			if (load.s4) v_s4 <= v_s3;
		end
	end

	// one lane per axis
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		pcr_axis u_axis (
			.clk        (clk),
			.load       (load),
			.active     (a < DIMS),
			.cell_idx   (s_tdata[a*CELL_BITS +: CELL_BITS]),
			.frac       (s_tdata[NUM_AXES*CELL_BITS + a*FRAC_BITS +: FRAC_BITS]),
			.scale      (scale_q[a]),
			.shift      (shift_q[a]),
			.src_ghosts (src_ghosts_q),
			.dst_ghosts (dst_ghosts_q),
			.new_cell   (new_cell[a]),
			.new_frac   (new_frac[a]),
			.clamped    (clamped[a])
		);
	end

	// output packing
	always_comb begin
		m_tdata = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			m_tdata[a*CELL_BITS +: CELL_BITS] = new_cell[a];
			m_tdata[NUM_AXES*CELL_BITS + a*FRAC_BITS +: FRAC_BITS] = new_frac[a];
		end
	end

	assign m_tvalid = v_s4;
	assign m_tuser  = |clamped;

	// some clamped axis must sit at a range edge
	always_comb begin
		clamp_shape_ok = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (clamped[a] && ((new_cell[a] == '0 && new_frac[a] == '0)
				|| (new_cell[a] == CELL_MAX && new_frac[a] == FRAC_MAX)))
				clamp_shape_ok = 1'b1;
		end
	end

	`PCR_ASSERT_SAME(a_ready_when_out_empty, !m_tvalid, s_tready, "pipe refuses input with empty output")
	`PCR_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, v_s1, "accepted transfer lost at stage 1")
	`PCR_ASSERT_SAME(a_full_stall_blocks, m_tvalid && !m_tready && v_s3 && v_s2 && v_s1, !s_tready, "full stalled pipe still ready")
	`PCR_ASSERT_SAME(a_clamp_at_edge, m_tvalid && m_tuser[0], clamp_shape_ok, "clamp flag without edge value")

endmodule

// ----- sv/pcr_axis.sv -----
// one axis lane of the remap pipeline: multiply, add shift, split, clamp
module pcr_axis import pcr_pkg::*; (
	input  logic      clk,
	input  pcr_load_t load,
	input  logic      active,
	input  cell_t     cell_idx,
	input  frac_t     frac,
	input  scale_t    scale,
	input  shift_t    shift,
	input  ghost_t    src_ghosts,
	input  ghost_t    dst_ghosts,
	output cell_t     new_cell,
	output frac_t     new_frac,
	output logic      clamped
);

	logic signed [DIFF_W-1:0]  diff;
	logic signed [MUL_W-1:0]   mul_c;
	logic [PROD_W-1:0]         prod_c;

	logic signed [MUL_W-1:0]   mul_s1;
	logic [PROD_W-1:0]         prod_s1;
	cell_t                     cell_s1;
	frac_t                     frac_s1;

	logic signed [WHOLE_W-1:0] whole_s2;
	logic [BHI_W-1:0]          bhi_s2;
	frac_t                     blo_s2;
	cell_t                     cell_s2;
	frac_t                     frac_s2;

	logic signed [AHI_W-1:0]   ahi_s3;
	logic [MID_W-1:0]          mid_s3;
	frac_t                     blo_s3;
	cell_t                     cell_s3;
	frac_t                     frac_s3;

	logic signed [CV_W-1:0]    cellv;
	logic [FRT_W-1:0]          frt;
	logic                      below;
	logic                      above;

	cell_t                     new_cell_s4;
	frac_t                     new_frac_s4;
	logic                      clamped_s4;

	// stage 1: cell minus source ghosts times scale, fraction times scale
	always_comb begin
		diff   = $signed({1'b0, cell_idx}) - $signed(DIFF_W'(src_ghosts));
		mul_c  = MUL_W'(diff) * $signed(MUL_W'(scale));
		prod_c = PROD_W'(frac) * PROD_W'(scale);
	end

	always_ff @(posedge clk) begin
		if (load.s1) begin
			mul_s1  <= mul_c;
			prod_s1 <= prod_c;
			cell_s1 <= cell_idx;
			frac_s1 <= frac;
		end
	end

	// stage 2: add origin shift, split fraction product
	always_ff @(posedge clk) begin
		if (load.s2) begin
			whole_s2 <= WHOLE_W'(mul_s1) + WHOLE_W'(shift);
			bhi_s2   <= prod_s1[PROD_W-1:FRAC_BITS];
			blo_s2   <= prod_s1[FRAC_BITS-1:0];
			cell_s2  <= cell_s1;
			frac_s2  <= frac_s1;
		end
	end

	// stage 3: floor of the whole part, merge low bits with fraction product
	always_ff @(posedge clk) begin
		if (load.s3) begin
			ahi_s3  <= whole_s2[WHOLE_W-1:QBITS];
			mid_s3  <= MID_W'(whole_s2[QBITS-1:0]) + MID_W'(bhi_s2);
			blo_s3  <= blo_s2;
			cell_s3 <= cell_s2;
			frac_s3 <= frac_s2;
		end
	end

	// stage 4: destination cell, leftover fraction, range check
	always_comb begin
		cellv = $signed(CV_W'(dst_ghosts)) + CV_W'(ahi_s3)
			+ $signed(CV_W'(mid_s3[MID_W-1:QBITS]));
		frt   = {mid_s3[QBITS-1:0], {FRAC_BITS{1'b0}}} + FRT_W'(blo_s3);
		below = cellv[CV_W-1];
		above = !below && (cellv > $signed(CV_W'(CELL_MAX)));
	end

	always_ff @(posedge clk) begin
		if (load.s4) begin
			priority if (!active) begin
				new_cell_s4 <= cell_s3;
				new_frac_s4 <= frac_s3;
				clamped_s4  <= 1'b0;
			end else if (below) begin
				new_cell_s4 <= '0;
				new_frac_s4 <= '0;
				clamped_s4  <= 1'b1;
			end else if (above) begin
				new_cell_s4 <= CELL_MAX;
				new_frac_s4 <= FRAC_MAX;
				clamped_s4  <= 1'b1;
			end else begin
				new_cell_s4 <= cellv[CELL_BITS-1:0];
				new_frac_s4 <= frt[FRT_W-1:QBITS];
				clamped_s4  <= 1'b0;
			end
		end
	end

	assign new_cell = new_cell_s4;
	assign new_frac = new_frac_s4;
	assign clamped  = clamped_s4;

endmodule

// ----- test/tb.sv -----
// testbench for the particle cell remap core: predicts every remap and checks the output stream
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcr_pkg::*;

	localparam int PAD_W          = TDATA_W - IN_W;
	localparam int PIPE_LATENCY   = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 150;
	localparam int PRESSURE_ITEMS = 40;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 230;

	typedef longint unsigned u64_t;

	// same layout as s_tdata and m_tdata: cells from the lowest bit, then fracs, then pad
	typedef struct packed {
		logic [PAD_W-1:0]           pad;
		frac_t [NUM_AXES-1:0]       frac;
		cell_t [NUM_AXES-1:0]       cell_idx;
	} particle_t;

	typedef struct packed {
		logic      out_of_range;
		particle_t pos;
	} remap_t;

	typedef struct packed {
		scale_t [NUM_AXES-1:0] scale;
		shift_t [NUM_AXES-1:0] shift;
		ghost_t                src_ghosts;
		ghost_t                dst_ghosts;
	} remap_regs_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	remap_regs_t cur_regs;
	remap_t      pending_remaps[$];
	int          error_count = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	bit          steady_send = 1'b0;
	bit          hold_request = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	int          ready_mode = 0;
	string       axis_names = "xyz";

	always #5 clk = ~clk;

	particle_cell_remap_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// expected remap of one particle under the current register settings
	function automatic remap_t remap_particle(input particle_t p);
		remap_t r;
		longint whole, ahi, cellv;
		u64_t   alo, prod, bhi, blo, mid, fr;
		int     a;
		r.pos = p;
		r.pos.pad = '0;
		r.out_of_range = 1'b0;
		for (a = 0; a < DIMS; a++) begin
			// whole cells times scale plus shift, Q.16 in destination cells
			whole = (longint'(p.cell_idx[a]) - longint'(cur_regs.src_ghosts))
				* longint'(cur_regs.scale[a]) + longint'($signed(cur_regs.shift[a]));
			ahi = whole >>> QBITS;
			alo = u64_t'(whole) & 64'hFFFF;
			// fraction times scale, split into carry part and leftover bits
			prod = u64_t'(p.frac[a]) * u64_t'(cur_regs.scale[a]);
			bhi = prod >> FRAC_BITS;
			blo = prod & ((64'd1 << FRAC_BITS) - 1);
			mid = alo + bhi;
			cellv = longint'(cur_regs.dst_ghosts) + ahi + longint'(mid >> QBITS);
			fr = (((mid & 64'hFFFF) << FRAC_BITS) + blo) >> QBITS;
			// clamp into the destination index range
			if (cellv < 0) begin
				cellv = 0;
				fr = 0;
				r.out_of_range = 1'b1;
			end else if (cellv > longint'(CELL_MAX)) begin
				cellv = longint'(CELL_MAX);
				fr = u64_t'(FRAC_MAX);
				r.out_of_range = 1'b1;
			end
			r.pos.cell_idx[a] = cell_t'(cellv);
			r.pos.frac[a] = frac_t'(fr);
		end
		return r;
	endfunction

	function automatic particle_t same_on_axes(input cell_t c, input frac_t f);
		particle_t p;
		p.pad = '0;
		p.cell_idx = {NUM_AXES{c}};
		p.frac = {NUM_AXES{f}};
		return p;
	endfunction

	function automatic particle_t random_particle();
		particle_t p;
		int        a;
		p = '0;
		for (a = 0; a < NUM_AXES; a++) begin
			p.cell_idx[a] = cell_t'($urandom);
			p.frac[a] = frac_t'($urandom);
			// keep some cells close to the source ghost band
			if ($urandom_range(0, 3) == 0)
				p.cell_idx[a] = cell_t'(cur_regs.src_ghosts + $urandom_range(0, 40));
		end
		return p;
	endfunction

	function automatic remap_regs_t uniform_regs(input scale_t s, input shift_t sh,
			input ghost_t src, input ghost_t dst);
		remap_regs_t r;
		r.scale = {NUM_AXES{s}};
		r.shift = {NUM_AXES{sh}};
		r.src_ghosts = src;
		r.dst_ghosts = dst;
		return r;
	endfunction

	function automatic remap_regs_t random_regs();
		remap_regs_t r;
		int          a;
		for (a = 0; a < NUM_AXES; a++) begin
			case ($urandom_range(0, 9))
				0:       r.scale[a] = '0;
				1:       r.scale[a] = '1;
				2:       r.scale[a] = scale_t'($urandom);
				default: r.scale[a] = scale_t'($urandom_range(8192, 262144));
			endcase
			if ($urandom_range(0, 4) == 0)
				r.shift[a] = shift_t'($urandom);
			else
				r.shift[a] = shift_t'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
		end
		r.src_ghosts = ghost_t'($urandom);
		r.dst_ghosts = ghost_t'($urandom);
		return r;
	endfunction

	// stop the input stream and wait until every remap in flight has come out
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_remaps.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// write all registers while the block is idle
	task automatic load_regs(input remap_regs_t r);
		drain_pipe();
		write_reg(REG_SCALE_X, CFG_DATA_W'(r.scale[0]));
		write_reg(REG_SCALE_Y, CFG_DATA_W'(r.scale[1]));
		write_reg(REG_SCALE_Z, CFG_DATA_W'(r.scale[2]));
		write_reg(REG_SHIFT_X, CFG_DATA_W'(r.shift[0]));
		write_reg(REG_SHIFT_Y, CFG_DATA_W'(r.shift[1]));
		write_reg(REG_SHIFT_Z, CFG_DATA_W'(r.shift[2]));
		write_reg(REG_SRC_GHOST, CFG_DATA_W'(r.src_ghosts));
		write_reg(REG_DST_GHOST, CFG_DATA_W'(r.dst_ghosts));
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_regs = r;
	endtask

	// offer one particle, with bursts and random gaps, and log its expected remap
	task automatic offer_particle(input particle_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = steady_send ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		p.pad = '0;
		s_tvalid <= 1'b1;
		s_tdata <= p;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_remaps = {pending_remaps, remap_particle(p)};
	endtask

	// identity mapping straight out of reset
	task automatic test_reset_values();
		offer_particle(same_on_axes('0, '0));
		offer_particle(same_on_axes(CELL_MAX, FRAC_MAX));
		offer_particle(random_particle());
		offer_particle(random_particle());
	endtask

	// source ghosts push the cell below zero
	task automatic test_clamp_below();
		load_regs(uniform_regs(SCALE_RESET, '0, 4'd15, 4'd0));
		offer_particle(same_on_axes(cell_t'(14), FRAC_MAX));
		offer_particle(same_on_axes(cell_t'(15), '0));
		offer_particle(same_on_axes('0, '0));
	endtask

	// destination ghosts push the cell past the top index
	task automatic test_clamp_above();
		load_regs(uniform_regs(SCALE_RESET, '0, 4'd0, 4'd15));
		offer_particle(same_on_axes(cell_t'(1008), FRAC_MAX));
		offer_particle(same_on_axes(cell_t'(1009), '0));
		offer_particle(same_on_axes(CELL_MAX, FRAC_MAX));
	endtask

	// zero scale: every particle lands on the shift, offset by the destination ghosts
	task automatic test_zero_scale();
		remap_regs_t r;
		r = uniform_regs('0, '0, 4'd7, 4'd1);
		r.shift[0] = shift_t'(32'h0003_8000);
		r.shift[1] = shift_t'(32'hFFFF_FFFF);
		r.shift[2] = shift_t'(32'h7FFF_FFFF);
		load_regs(r);
		offer_particle(same_on_axes('0, '0));
		offer_particle(same_on_axes(CELL_MAX, FRAC_MAX));
		offer_particle(random_particle());
	endtask

	// largest scale with the most negative and most positive shifts
	task automatic test_register_extremes();
		remap_regs_t r;
		particle_t   p;
		r = uniform_regs('1, '0, 4'd15, 4'd15);
		r.shift[0] = shift_t'(32'h8000_0000);
		r.shift[1] = shift_t'(32'h7FFF_FFFF);
		load_regs(r);
		offer_particle(same_on_axes('0, '0));
		offer_particle(same_on_axes(CELL_MAX, FRAC_MAX));
		offer_particle(same_on_axes(cell_t'(15), frac_t'(1)));
		offer_particle(same_on_axes(cell_t'(15), '0));
		p = same_on_axes(cell_t'(16), frac_t'(16'h8000));
		p.cell_idx[0] = CELL_MAX;
		p.cell_idx[1] = '0;
		offer_particle(p);
	endtask

	// long receiver hold-off while the sender keeps offering, so the pipe fills
	task automatic test_backpressure();
		load_regs(random_regs());
		steady_send = 1'b1;
		hold_request = 1'b1;
		repeat (PRESSURE_ITEMS) offer_particle(random_particle());
		steady_send = 1'b0;
	endtask

	// random particles under a series of random register settings
	task automatic test_random_stream();
		int phase;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			load_regs(random_regs());
			repeat (PHASE_ITEMS) offer_particle(random_particle());
		end
	endtask

	// receiver: changing ready patterns, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (ready_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// compare each output transfer with the oldest expected remap
	always @(posedge clk) begin : check_output
		remap_t want;
		remap_t got;
		int     a;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_remaps.size() == 0) begin
				$error("output transfer with no particle pending");
				error_count++;
			end else begin
				want = pending_remaps.pop_front();
				got.pos = particle_t'(m_tdata);
				got.out_of_range = m_tuser[0];
				for (a = 0; a < NUM_AXES; a++) begin
					if (got.pos.cell_idx[a] !== want.pos.cell_idx[a]) begin
						$error("new_cell_%c: expected %0d, got %0d", axis_names[a],
							want.pos.cell_idx[a], got.pos.cell_idx[a]);
						error_count++;
					end
					if (got.pos.frac[a] !== want.pos.frac[a]) begin
						$error("new_frac_%c: expected %0d, got %0d", axis_names[a],
							want.pos.frac[a], got.pos.frac[a]);
						error_count++;
					end
				end
				if (got.out_of_range !== want.out_of_range) begin
					$error("out_of_range: expected %0d, got %0d", want.out_of_range,
						got.out_of_range);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		cur_regs = uniform_regs(SCALE_RESET, '0, '0, '0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_clamp_below();
		test_clamp_above();
		test_zero_scale();
		test_register_extremes();
		test_backpressure();
		test_random_stream();
		drain_pipe();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
